>>> hw/rtl/opcode_pair_histogram_core_assert.svh
// Assertion macros shared by the opcode pair histogram modules.
// Each macro takes a label, the clock, the active-low reset, a condition
// and the property that must follow from it.
`ifndef OPCODE_PAIR_HISTOGRAM_CORE_ASSERT_SVH
`define OPCODE_PAIR_HISTOGRAM_CORE_ASSERT_SVH
`ifndef SYNTH
// Consequent must hold in the same cycle as the condition.
`define OPH_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("opcode pair histogram: property failed");
// Consequent must hold in the cycle after the condition.
`define OPH_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("opcode pair histogram: property failed");
`else
`define OPH_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define OPH_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

>>> hw/rtl/ophist_pkg.sv
package ophist_pkg;

    // Sizes of the opcode space and the counters.
    localparam int OPCODE_SLOTS    = 512;
    localparam int SLOT_W          = $clog2(OPCODE_SLOTS);
    localparam int PAIR_ADDR_W     = 2 * SLOT_W;
    localparam int PAIR_DEPTH      = OPCODE_SLOTS * OPCODE_SLOTS;
    localparam int PAIR_COUNT_BITS = 32;
    localparam int COUNT_W         = 64;
    localparam int OP_W            = 3;
    localparam int BYTE_W          = 8;

    localparam logic [PAIR_COUNT_BITS-1:0] PAIR_MAX = {PAIR_COUNT_BITS{1'b1}};
    localparam logic [SLOT_W-1:0]          TWO_BYTE_BASE = SLOT_W'(256);

    // Operation codes of an input transfer.
    typedef enum logic [OP_W-1:0] {
        OP_BEGIN    = 3'd0,
        OP_SECOND   = 3'd1,
        OP_FLUSH    = 3'd2,
        OP_RD_OPC   = 3'd3,
        OP_RD_PAIR  = 3'd4,
        OP_RD_TOTAL = 3'd5
    } t_op;

    // Controller states.
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_CMT_WR,
        S_EMIT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr_wr;
        logic load;
        logic mem_rd;
        logic rd_commit;
        logic commit_wr;
        logic set_pending;
        logic set_second;
        logic inc_total;
        logic emit;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            pend_valid;
        logic            clr_last;
    } t_stat;

endpackage

>>> hw/rtl/ophist_ctl.sv
`include "opcode_pair_histogram_core_assert.svh"

module ophist_ctl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  ophist_pkg::t_stat i_stat,
    output ophist_pkg::t_cmd  o_cmd
);
    import ophist_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   accept;
    logic   clearing;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign accept   = i_start && !o_busy;
    assign clearing = (r_state == S_CLEAR) && !i_stat.clr_last;

    // Next state and datapath commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b1;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_IDLE;
                case (i_stat.op)
                    OP_BEGIN: begin
                        o_cmd.inc_total = 1'b1;
                        if (i_stat.pend_valid) begin
                            o_cmd.mem_rd    = 1'b1;
                            o_cmd.rd_commit = 1'b1;
                            n_state         = S_CMT_WR;
                        end else begin
                            o_cmd.set_pending = 1'b1;
                        end
                    end
                    OP_SECOND: begin
                        o_cmd.set_second = 1'b1;
                    end
                    OP_FLUSH: begin
                        if (i_stat.pend_valid) begin
                            o_cmd.mem_rd    = 1'b1;
                            o_cmd.rd_commit = 1'b1;
                            n_state         = S_CMT_WR;
                        end
                    end
                    OP_RD_OPC, OP_RD_PAIR, OP_RD_TOTAL: begin
                        o_cmd.mem_rd = 1'b1;
                        n_state      = S_EMIT;
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_CMT_WR: begin
                // A begin makes its own opcode pending once the old one is recorded.
                o_cmd.commit_wr = 1'b1;
                if (i_stat.op == OP_BEGIN) begin
                    o_cmd.set_pending = 1'b1;
                end
                n_state = S_IDLE;
            end
            S_EMIT: begin
                o_cmd.emit = 1'b1;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    `OPH_ASSERT_NEXT(a_accept_decode, i_clk, i_rst_n, accept, r_state == S_DECODE)
    `OPH_ASSERT_IMPL(a_commit_pending, i_clk, i_rst_n, o_cmd.commit_wr, i_stat.pend_valid)
    `OPH_ASSERT_NEXT(a_clear_holds, i_clk, i_rst_n, clearing, r_state == S_CLEAR)

endmodule

>>> hw/rtl/ophist_dp.sv
`include "opcode_pair_histogram_core_assert.svh"

module ophist_dp (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  ophist_pkg::t_cmd                          i_cmd,
    output ophist_pkg::t_stat                         o_stat,
    input  logic [ophist_pkg::OP_W-1:0]               i_operation,
    input  logic [ophist_pkg::BYTE_W-1:0]             i_opcode_byte,
    input  logic [ophist_pkg::SLOT_W-1:0]             i_read_first,
    input  logic [ophist_pkg::SLOT_W-1:0]             i_read_second,
    output logic                                      o_strobe,
    output logic [ophist_pkg::COUNT_W-1:0]            o_count_value
);
    import ophist_pkg::*;

    // Count stores.
    logic [COUNT_W-1:0]         opc_mem  [OPCODE_SLOTS];
    logic [PAIR_COUNT_BITS-1:0] pair_mem [PAIR_DEPTH];

    // Latched input transfer.
    logic [OP_W-1:0]   r_op;
    logic [BYTE_W-1:0] r_byte;
    logic [SLOT_W-1:0] r_rd_first;
    logic [SLOT_W-1:0] r_rd_second;

    // Tracking state.
    logic [SLOT_W:0]      r_prev;
    logic [SLOT_W-1:0]    r_pend;
    logic                 r_pend_valid;
    logic [COUNT_W-1:0]   r_total;
    logic [PAIR_ADDR_W-1:0] r_clr_cnt;

    // Registered read data and result.
    logic [COUNT_W-1:0]         r_opc_q;
    logic [PAIR_COUNT_BITS-1:0] r_pair_q;
    logic                       r_valid;
    logic [COUNT_W-1:0]         r_count;

    logic [SLOT_W-1:0]          opc_rd_addr;
    logic [PAIR_ADDR_W-1:0]     pair_rd_addr;
    logic [PAIR_ADDR_W-1:0]     commit_addr;
    logic [PAIR_COUNT_BITS-1:0] pair_wdata;
    logic                       pair_we;
    logic [SLOT_W:0]            pend_ext;

    // Read addresses come from the pending opcode during a commit.
    assign commit_addr  = {r_prev[SLOT_W-1:0], r_pend};
    assign opc_rd_addr  = i_cmd.rd_commit ? r_pend : r_rd_first;
    assign pair_rd_addr = i_cmd.rd_commit ? commit_addr : {r_rd_first, r_rd_second};
    assign pend_ext     = {1'b0, r_pend};

    // Pair counts saturate; no pair exists before the first commit.
    assign pair_wdata = (r_pair_q == PAIR_MAX) ? r_pair_q : r_pair_q + 1'b1;
    assign pair_we    = i_cmd.commit_wr && !r_prev[SLOT_W];

    // Opcode count store.
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_wr) begin
            opc_mem[r_clr_cnt[SLOT_W-1:0]] <= '0;
        end else if (i_cmd.commit_wr) begin
            opc_mem[r_pend] <= r_opc_q + 1'b1;
        end
        if (i_cmd.mem_rd) begin
            r_opc_q <= opc_mem[opc_rd_addr];
        end
    end

    // Pair count store.
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_wr) begin
            pair_mem[r_clr_cnt] <= '0;
        end else if (pair_we) begin
            pair_mem[commit_addr] <= pair_wdata;
        end
        if (i_cmd.mem_rd) begin
            r_pair_q <= pair_mem[pair_rd_addr];
        end
    end

    // Input capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op        <= i_operation;
            r_byte      <= i_opcode_byte;
            r_rd_first  <= i_read_first;
            r_rd_second <= i_read_second;
        end
    end

    // Clearing sweep counter, previous and pending opcodes, and the total.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt    <= '0;
            r_prev       <= (SLOT_W+1)'(OPCODE_SLOTS);
            r_pend       <= '0;
            r_pend_valid <= 1'b0;
            r_total      <= '0;
        end else begin
            if (i_cmd.clr_wr) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
            end
            if (i_cmd.inc_total) begin
                r_total <= r_total + 1'b1;
            end
            if (i_cmd.commit_wr) begin
                r_prev <= {1'b0, r_pend};
            end
            if (i_cmd.set_second) begin
                r_pend <= TWO_BYTE_BASE + SLOT_W'(r_byte);
            end else if (i_cmd.set_pending) begin
                r_pend <= SLOT_W'(r_byte);
            end
            // A begin that commits also makes its own opcode pending.
            if (i_cmd.set_pending) begin
                r_pend_valid <= 1'b1;
            end else if (i_cmd.commit_wr) begin
                r_pend_valid <= 1'b0;
            end
        end
    end

    // Result register, shown for one cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            case (r_op)
                OP_RD_OPC:  r_count <= r_opc_q;
                OP_RD_PAIR: r_count <= COUNT_W'(r_pair_q);
                default:    r_count <= r_total;
            endcase
        end
    end

    assign o_stat.op         = r_op;
    assign o_stat.pend_valid = r_pend_valid;
    assign o_stat.clr_last   = &r_clr_cnt;
    assign o_strobe          = r_valid;
    assign o_count_value     = r_count;

    `OPH_ASSERT_NEXT(a_emit_strobe, i_clk, i_rst_n, i_cmd.emit, r_valid)
    `OPH_ASSERT_NEXT(a_strobe_single, i_clk, i_rst_n, r_valid, !r_valid)
    `OPH_ASSERT_NEXT(a_commit_prev, i_clk, i_rst_n, i_cmd.commit_wr, r_prev == $past(pend_ext))

endmodule

>>> hw/rtl/opcode_pair_histogram_core.sv
// Opcode and adjacent opcode pair histogram.
// A read result is registered onto o_count_value, with o_strobe, after DECODE and EMIT.
// Busy stays high until an item is done: second bytes, unused codes and items that
// record nothing use DECODE; reads add EMIT; a begin or flush that commits adds CMT_WR.
// Reset: a sweep over all 262144 pair entries zeroes both count stores; busy stays high meanwhile.
// Results cannot be stalled; each is valid for exactly one cycle.
module opcode_pair_histogram_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [ophist_pkg::OP_W-1:0]          i_operation,
    input  logic [ophist_pkg::BYTE_W-1:0]        i_opcode_byte,
    input  logic [ophist_pkg::SLOT_W-1:0]        i_read_first,
    input  logic [ophist_pkg::SLOT_W-1:0]        i_read_second,
    output logic                                 o_strobe,
    output logic [ophist_pkg::COUNT_W-1:0]       o_count_value
);
    import ophist_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // Sequencer for clearing, commits and reads.
    ophist_ctl u_ctl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // Count stores and tracking registers.
    ophist_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_operation   (i_operation),
        .i_opcode_byte (i_opcode_byte),
        .i_read_first  (i_read_first),
        .i_read_second (i_read_second),
        .o_strobe      (o_strobe),
        .o_count_value (o_count_value)
    );

endmodule
